@@ src/bfs_pkg.sv @@
// ----------------------------------------------------------------------------
// bfs_pkg
// shared types and codes for the first-step path finder
// ----------------------------------------------------------------------------
package bfs_pkg;

    localparam int ROOM_W = 10;
    localparam int DIR_W  = 3;
    localparam int DIST_W = 10;
    localparam int STAT_W = 3;

    typedef enum logic [1:0] {
        REQ_EXIT  = 2'd0,
        REQ_FLAG  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_FOUND  = 3'd0,
        ST_THERE  = 3'd1,
        ST_NOPATH = 3'd2,
        ST_RANGE  = 3'd3,
        ST_WRITE  = 3'd4
    } stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_POP,
        S_POPW,
        S_EXRD,
        S_EXWT,
        S_VISRD,
        S_VISWT,
        S_OUT
    } state_t;

endpackage

@@ src/bfs_ram.sv @@
// ----------------------------------------------------------------------------
// bfs_ram
// single-port write, single-port read ram with registered read data
// ----------------------------------------------------------------------------
module bfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/bfs_first_step_path_finder.sv @@
// ----------------------------------------------------------------------------
// bfs_first_step_path_finder
// breadth-first search over a stored graph returning first exit and hops
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | req_type room dir exit_present ...
// out     | output    | out_valid/out_ready | status first_dir distance
// cfg     | input     | cfg_we              | cfg_wdata (room_top)
//
// writes and queries answered without a search go straight to the result; a search
// first clears the visited bits of rooms 0..top, then dequeues nodes in order and
// reads each exit of the node, checking the visited and no-track bits of an exit
// that leads to an in-range node before that node is queued
// after reset the exit valid bits are swept clear, during which no item is
// accepted; the no-track memory is swept alongside
// one item is in flight at a time; a waiting result holds the block
// ----------------------------------------------------------------------------
module bfs_first_step_path_finder #(
    parameter int MAX_ROOMS = 1024,
    parameter int NUM_DIRS  = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   req_type,
    input  logic [bfs_pkg::ROOM_W-1:0]   room,
    input  logic [bfs_pkg::DIR_W-1:0]    dir,
    input  logic                         exit_present,
    input  logic [bfs_pkg::ROOM_W-1:0]   dest_room,
    input  logic                         no_track,
    input  logic [bfs_pkg::ROOM_W-1:0]   target_room,
    input  logic                         honor_no_track,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bfs_pkg::STAT_W-1:0]   status,
    output logic [bfs_pkg::DIR_W-1:0]    first_dir,
    output logic [bfs_pkg::DIST_W-1:0]   distance,
    input  logic                         cfg_we,
    input  logic [bfs_pkg::ROOM_W-1:0]   cfg_wdata
);
    import bfs_pkg::*;

    localparam int NW      = $clog2(MAX_ROOMS);
    localparam int EDEPTH  = MAX_ROOMS * NUM_DIRS;
    localparam int EW      = $clog2(EDEPTH);
    localparam int DW      = (NUM_DIRS > 1) ? $clog2(NUM_DIRS) : 1;
    localparam int QW      = NW + 1;
    localparam int HW      = NW + 1;
    localparam int QDW     = NW + DIR_W + HW;

    // effective top: min(room_top, MAX_ROOMS-1)
    logic [ROOM_W-1:0] room_top_reg;
    logic [ROOM_W-1:0] top_w;
    always_comb
    begin
        if (int'(room_top_reg) > MAX_ROOMS - 1)
            top_w = ROOM_W'(MAX_ROOMS - 1);
        else
            top_w = room_top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            room_top_reg <= '1;
        else if (cfg_we)
            room_top_reg <= cfg_wdata;
    end

    state_t state_reg, state_next;

    // captured request
    logic [NW-1:0]     src_reg, tgt_reg;
    logic              honor_reg;
    logic [ROOM_W-1:0] cnt_reg, cnt_next;         // clear sweep counter
    logic              init_reg, init_next;       // reset sweep still running
    logic [EW:0]       icnt_reg, icnt_next;
    // search state
    logic [QW-1:0]     head_reg, head_next, tail_reg, tail_next;
    logic              first_reg, first_next;     // expanding the source
    logic [NW-1:0]     cur_reg, cur_next;
    logic [DIR_W-1:0]  fd_reg, fd_next;
    logic [HW-1:0]     hops_reg, hops_next;
    logic [DW-1:0]     d_reg, d_next;
    logic [NW-1:0]     to_reg, to_next;
    // result
    logic [STAT_W-1:0] st_reg, st_next;
    logic [DIR_W-1:0]  rd_reg, rd_next;
    logic [DIST_W-1:0] rh_reg, rh_next;

    // memories
    logic              ev_we, ev_wd, ev_rd;
    logic [EW-1:0]     ev_wa, ev_ra;
    logic              ed_we;
    logic [ROOM_W-1:0] ed_wd, ed_rd;
    logic              nt_we, nt_wd, nt_rd;
    logic [NW-1:0]     nt_wa, nt_ra;
    logic              vi_we, vi_wd, vi_rd;
    logic [NW-1:0]     vi_wa, vi_ra;
    logic              q_we;
    logic [NW-1:0]     q_wa, q_ra;
    logic [QDW-1:0]    q_wd, q_rd;

    bfs_ram #(.WIDTH(1),  .DEPTH(EDEPTH)) u_ev (.clk, .we(ev_we), .waddr(ev_wa),
        .wdata(ev_wd), .raddr(ev_ra), .rdata(ev_rd));
    bfs_ram #(.WIDTH(ROOM_W), .DEPTH(EDEPTH)) u_ed (.clk, .we(ed_we), .waddr(ev_wa),
        .wdata(ed_wd), .raddr(ev_ra), .rdata(ed_rd));
    bfs_ram #(.WIDTH(1),  .DEPTH(MAX_ROOMS)) u_nt (.clk, .we(nt_we), .waddr(nt_wa),
        .wdata(nt_wd), .raddr(nt_ra), .rdata(nt_rd));
    bfs_ram #(.WIDTH(1),  .DEPTH(MAX_ROOMS)) u_vi (.clk, .we(vi_we), .waddr(vi_wa),
        .wdata(vi_wd), .raddr(vi_ra), .rdata(vi_rd));
    bfs_ram #(.WIDTH(QDW), .DEPTH(MAX_ROOMS)) u_q (.clk, .we(q_we), .waddr(q_wa),
        .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

    // request decode
    logic [EW+1:0] wr_idx;
    logic          room_ok, dir_ok;
    assign wr_idx  = (EW+2)'(room) * (EW+2)'(NUM_DIRS) + (EW+2)'(dir);
    assign room_ok = (int'(room) < MAX_ROOMS);
    assign dir_ok  = (int'(dir) < NUM_DIRS);

    // exit address of current node and direction
    logic [EW+1:0] ex_idx;
    assign ex_idx = (EW+2)'(cur_reg) * (EW+2)'(NUM_DIRS) + (EW+2)'(d_reg);

    assign in_ready  = (state_reg == S_IDLE) && !init_reg;
    assign out_valid = (state_reg == S_OUT);
    assign status    = st_reg;
    assign first_dir = rd_reg;
    assign distance  = rh_reg;

    logic [NW-1:0] q_node;
    logic [DIR_W-1:0] q_fd;
    logic [HW-1:0] q_hops;
    assign {q_node, q_fd, q_hops} = q_rd;

    // hop count never exceeds the node count, so it cannot wrap
    logic [HW-1:0] hp1;
    assign hp1 = hops_reg + HW'(1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        init_next  = init_reg;
        icnt_next  = icnt_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        first_next = first_reg;
        cur_next   = cur_reg;
        fd_next    = fd_reg;
        hops_next  = hops_reg;
        d_next     = d_reg;
        to_next    = to_reg;
        st_next    = st_reg;
        rd_next    = rd_reg;
        rh_next    = rh_reg;
        ev_we = 1'b0; ev_wd = 1'b0; ev_wa = '0; ev_ra = ex_idx[EW-1:0];
        ed_we = 1'b0; ed_wd = dest_room;
        nt_we = 1'b0; nt_wd = 1'b0; nt_wa = '0; nt_ra = to_reg;
        vi_we = 1'b0; vi_wd = 1'b0; vi_wa = '0; vi_ra = to_reg;
        q_we  = 1'b0; q_wa = tail_reg[NW-1:0]; q_ra = head_reg[NW-1:0];
        q_wd  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (init_reg)
                begin
                    // reset sweep over exit valid bits and no-track flags
                    ev_we = 1'b1;
                    ev_wa = icnt_reg[EW-1:0];
                    if (icnt_reg < (EW+1)'(MAX_ROOMS))
                    begin
                        nt_we = 1'b1;
                        nt_wa = icnt_reg[NW-1:0];
                    end
                    icnt_next = icnt_reg + (EW+1)'(1);
                    if (icnt_reg == (EW+1)'(EDEPTH-1))
                        init_next = 1'b0;
                end
                else if (in_valid)
                begin
                    st_next = ST_WRITE; rd_next = '0; rh_next = '0;
                    unique case (req_t'(req_type))
                        REQ_EXIT:
                        begin
                            if (room_ok && dir_ok)
                            begin
                                ev_we = 1'b1; ed_we = 1'b1;
                                ev_wa = wr_idx[EW-1:0];
                                ev_wd = exit_present;
                            end
                            state_next = S_OUT;
                        end
                        REQ_FLAG:
                        begin
                            if (room_ok)
                            begin
                                nt_we = 1'b1;
                                nt_wa = NW'(room);
                                nt_wd = no_track;
                            end
                            state_next = S_OUT;
                        end
                        REQ_QUERY:
                        begin
                            if (room > top_w || target_room > top_w)
                            begin
                                st_next = ST_RANGE;
                                state_next = S_OUT;
                            end
                            else if (room == target_room)
                            begin
                                st_next = ST_THERE;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                state_next = S_CLEAR;
                            end
                        end
                        default:
                        begin
                            st_next = ST_RANGE;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                vi_we = 1'b1;
                vi_wa = NW'(cnt_reg);
                vi_wd = (NW'(cnt_reg) == src_reg);
                cnt_next = cnt_reg + ROOM_W'(1);
                if (cnt_reg == top_w)
                begin
                    head_next = '0; tail_next = '0;
                    first_next = 1'b1;
                    cur_next = src_reg; fd_next = '0; hops_next = '0;
                    d_next = '0;
                    state_next = S_EXRD;
                end
            end
            S_POP:
            begin
                if (head_reg >= tail_reg)
                begin
                    st_next = ST_NOPATH; rd_next = '0; rh_next = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                // the source is never queued, so every popped node is a child
                first_next = 1'b0;
                head_next = head_reg + QW'(1);
                cur_next  = q_node; fd_next = q_fd; hops_next = q_hops;
                d_next    = '0;
                if (q_node == tgt_reg)
                begin
                    st_next = ST_FOUND;
                    rd_next = q_fd;
                    rh_next = (q_hops > HW'(1023)) ? DIST_W'(1023) : DIST_W'(q_hops);
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_EXRD;
                end
            end
            S_EXRD:
            begin
                state_next = S_EXWT;
            end
            S_EXWT:
            begin
                to_next = NW'(ed_rd);
                if (ev_rd && (ed_rd <= top_w))
                    state_next = S_VISRD;
                else if (d_reg == DW'(NUM_DIRS-1))
                    state_next = S_POP;
                else
                begin
                    // skipped exit, next direction
                    d_next = d_reg + DW'(1);
                    state_next = S_EXRD;
                end
            end
            S_VISRD:
            begin
                state_next = S_VISWT;
            end
            S_VISWT:
            begin
                if (!vi_rd && !(honor_reg && nt_rd) &&
                    tail_reg < QW'(MAX_ROOMS))
                begin
                    vi_we = 1'b1; vi_wa = to_reg; vi_wd = 1'b1;
                    q_we  = 1'b1;
                    q_wd  = {to_reg, first_reg ? DIR_W'(d_reg) : fd_reg, hp1};
                    tail_next = tail_reg + QW'(1);
                end
                if (d_reg == DW'(NUM_DIRS-1))
                begin
                    first_next = 1'b0;
                    state_next = S_POP;
                end
                else
                begin
                    d_next = d_reg + DW'(1);
                    state_next = S_EXRD;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            init_reg  <= 1'b1;
            icnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            icnt_reg  <= icnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            src_reg   <= NW'(room);
            tgt_reg   <= NW'(target_room);
            honor_reg <= honor_no_track;
        end
        cnt_reg   <= cnt_next;
        head_reg  <= head_next;
        tail_reg  <= tail_next;
        first_reg <= first_next;
        cur_reg   <= cur_next;
        fd_reg    <= fd_next;
        hops_reg  <= hops_next;
        d_reg     <= d_next;
        to_reg    <= to_next;
        st_reg    <= st_next;
        rd_reg    <= rd_next;
        rh_reg    <= rh_next;
    end

    // queue never runs past its tail
    a_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POPW) |-> (head_reg < tail_reg))
        else $error("dequeue from empty queue");
    // no transfer accepted during the reset sweep
    a_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> !in_ready)
        else $error("accepted during sweep");
    // a found result always has at least one hop
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FOUND) |-> (distance != '0))
        else $error("found with zero hops");

endmodule

@@ tb/sv/bfs_first_step_path_finder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfs_first_step_path_finder_tb
// drives graph writes and path queries through the request channel, predicts
// each answer with an in-bench breadth-first search, and checks every result
// ----------------------------------------------------------------------------
module bfs_first_step_path_finder_tb;

    import bfs_pkg::*;

    localparam int NODES = 1024;
    localparam int EXITS = 6;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          req_type;
    logic [ROOM_W-1:0]   room;
    logic [DIR_W-1:0]    dir;
    logic                exit_present;
    logic [ROOM_W-1:0]   dest_room;
    logic                no_track;
    logic [ROOM_W-1:0]   target_room;
    logic                honor_no_track;
    logic                out_valid;
    logic                out_ready;
    logic [STAT_W-1:0]   status;
    logic [DIR_W-1:0]    first_dir;
    logic [DIST_W-1:0]   distance;
    logic                cfg_we;
    logic [ROOM_W-1:0]   cfg_wdata;

    typedef struct packed {
        logic [STAT_W-1:0] st;
        logic [DIR_W-1:0]  fd;
        logic [DIST_W-1:0] hops;
    } answer_t;

    // mirror of the graph held by the block
    logic              link_on   [NODES*EXITS];
    logic [ROOM_W-1:0] link_to   [NODES*EXITS];
    logic              avoid_node[NODES];
    logic [ROOM_W-1:0] top_room;

    answer_t answers_due[$];
    int      fail_count;
    bit      done;

    bfs_first_step_path_finder uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .room           (room),
        .dir            (dir),
        .exit_present   (exit_present),
        .dest_room      (dest_room),
        .no_track       (no_track),
        .target_room    (target_room),
        .honor_no_track (honor_no_track),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .first_dir      (first_dir),
        .distance       (distance),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // breadth-first search, nodes marked when queued, exits in order
    function automatic answer_t shortest_step(input logic [ROOM_W-1:0] src,
                                              input logic [ROOM_W-1:0] tgt,
                                              input logic honor);
        answer_t r;
        bit seen[NODES];
        int q_node[$];
        int q_dir[$];
        int q_hops[$];
        int cur, fd, h, to;
        r = '0;
        if (src > top_room || tgt > top_room)
        begin
            r.st = ST_RANGE;
            return r;
        end
        if (src == tgt)
        begin
            r.st = ST_THERE;
            return r;
        end
        seen[src] = 1'b1;
        q_node.push_back(src);
        q_dir.push_back(0);
        q_hops.push_back(0);
        while (q_node.size() > 0)
        begin
            cur = q_node.pop_front();
            fd  = q_dir.pop_front();
            h   = q_hops.pop_front();
            if (cur == tgt)
            begin
                r.st   = ST_FOUND;
                r.fd   = DIR_W'(fd);
                r.hops = DIST_W'((h > 1023) ? 1023 : h);
                return r;
            end
            for (int d = 0; d < EXITS; d++)
            begin
                if (!link_on[cur*EXITS+d])
                    continue;
                to = link_to[cur*EXITS+d];
                if (to > top_room || seen[to])
                    continue;
                if (honor && avoid_node[to])
                    continue;
                seen[to] = 1'b1;
                q_node.push_back(to);
                q_dir.push_back(h == 0 ? d : fd);
                q_hops.push_back(h + 1);
            end
        end
        r.st = ST_NOPATH;
        return r;
    endfunction

    // take the request lines idle after the last transfer
    task automatic drop_input();
        in_valid <= 1'b0;
    endtask

    // predict, then hand one request to the block; returns at the falling edge
    // after the transfer with valid still up, the next call or drop_input clears it
    task automatic send_request(input req_t t, input int rm, input int dr, input bit pres,
                                input int dst, input bit flag, input int tgt,
                                input bit honor);
        answer_t a;
        int gap;
        a = '0;
        case (t)
            REQ_EXIT:
            begin
                if (dr < EXITS)
                begin
                    link_on[rm*EXITS+dr] = pres;
                    link_to[rm*EXITS+dr] = ROOM_W'(dst);
                end
                a.st = ST_WRITE;
            end
            REQ_FLAG:
            begin
                avoid_node[rm] = flag;
                a.st = ST_WRITE;
            end
            REQ_QUERY: a = shortest_step(ROOM_W'(rm), ROOM_W'(tgt), honor);
            default:   a.st = ST_RANGE;
        endcase
        answers_due.push_back(a);
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= t;
        room           <= ROOM_W'(rm);
        dir            <= DIR_W'(dr);
        exit_present   <= pres;
        dest_room      <= ROOM_W'(dst);
        no_track       <= flag;
        target_room    <= ROOM_W'(tgt);
        honor_no_track <= honor;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_exit(input int rm, input int dr, input bit pres, input int dst);
        send_request(REQ_EXIT, rm, dr, pres, dst, 1'($urandom_range(0, 1)),
                     $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_query(input int src, input int tgt, input bit honor);
        send_request(REQ_QUERY, src, $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 1023), 1'($urandom_range(0, 1)), tgt, honor);
    endtask

    // wait until the block is idle, then load room_top
    task automatic set_room_top(input int v);
        drop_input();
        while (answers_due.size() > 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ROOM_W'(v);
        @(negedge clk);
        cfg_we <= 1'b0;
        top_room = ROOM_W'(v);
    endtask

    // result check, one transfer per rising edge with valid and ready high
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (answers_due.size() == 0)
            begin
                $error("unexpected result status=%0d", status);
                fail_count++;
            end
            else
            begin
                answer_t e;
                e = answers_due.pop_front();
                if (status !== e.st)
                begin
                    $error("status expected %0d actual %0d", e.st, status);
                    fail_count++;
                end
                if (first_dir !== e.fd)
                begin
                    $error("first_dir expected %0d actual %0d", e.fd, first_dir);
                    fail_count++;
                end
                if (distance !== e.hops)
                begin
                    $error("distance expected %0d actual %0d", e.hops, distance);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls drawn per result
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            wait_n = $urandom_range(0, 5);
            out_ready <= (wait_n == 0);
            if (wait_n != 0)
            begin
                repeat (wait_n) @(negedge clk);
                out_ready <= 1'b1;
            end
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // every field extreme, every request type, each special case
    task automatic test_directed();
        send_exit(0, 0, 1, 1);
        send_exit(1, 5, 1, 2);
        send_exit(2, 3, 1, 1023);
        send_exit(0, 5, 1, 3);
        send_exit(3, 1, 1, 2);
        send_exit(0, 7, 1, 5);                         // exit number out of range
        send_exit(1023, 2, 1, 0);
        send_query(0, 2, 0);                           // two hops, first exit 0
        send_query(0, 1023, 0);
        send_query(5, 5, 1);                           // already there
        send_query(1023, 1, 0);
        send_query(0, 500, 0);                         // no path
        send_request(REQ_FLAG, 2, 0, 0, 0, 1, 0, 0);
        send_request(REQ_FLAG, 1, 0, 0, 0, 1, 0, 0);
        send_query(0, 2, 1);                           // no-track target skipped
        send_query(0, 2, 0);
        send_query(2, 2, 1);
        send_request(REQ_NONE, 1023, 7, 1, 1023, 1, 1023, 1);
        send_exit(1, 5, 0, 2);                         // remove exit
        send_query(0, 2, 0);
    endtask

    task automatic test_room_top();
        set_room_top(2);
        send_query(0, 1023, 0);                        // target out of range
        send_query(3, 0, 0);                           // source out of range
        send_query(0, 2, 0);
        set_room_top(0);
        send_query(0, 0, 0);
        send_query(0, 1, 0);
        set_room_top(1023);
        send_query(0, 1023, 0);
    endtask

    // small dense graph so queries find real paths
    task automatic test_random();
        int k;
        for (k = 0; k < 75; k++)
        begin
            int sel;
            sel = $urandom_range(0, 9);
            if (sel < 4)
                send_exit($urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 3) != 0,
                          ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 15));
            else if (sel == 4)
                send_request(REQ_FLAG, $urandom_range(0, 1023), $urandom_range(0, 7),
                             1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                             $urandom_range(0, 3) == 0, $urandom_range(0, 1023),
                             1'($urandom_range(0, 1)));
            else if (sel == 9)
                send_request(REQ_NONE, $urandom_range(0, 1023), $urandom_range(0, 7),
                             1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                             1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                             1'($urandom_range(0, 1)));
            else
                send_query($urandom_range(0, 15),
                           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 15),
                           1'($urandom_range(0, 1)));
            if (k == 50)
                set_room_top($urandom_range(4, 12));   // also drains all results
        end
    endtask

    initial
    begin
        foreach (link_on[i])
        begin
            link_on[i] = 1'b0;
            link_to[i] = '0;
        end
        foreach (avoid_node[i])
            avoid_node[i] = 1'b0;
        top_room       = 10'd1023;
        fail_count     = 0;
        done           = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        req_type       = REQ_EXIT;
        room           = '0;
        dir            = '0;
        exit_present   = 1'b0;
        dest_room      = '0;
        no_track       = 1'b0;
        target_room    = '0;
        honor_no_track = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_room_top();
        test_random();
        drop_input();
        while (answers_due.size() > 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        done = 1'b1;
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog: about 100 items, each up to a full search, plus stalls and reset sweep
    initial
    begin
        #100ms;
        if (!done)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
